// File: rtl/h3fp_pkg.sv
// Package for the HTTP/3 frame parser: phase codes, result kinds, constants.
// No dependencies.
`default_nettype none
package h3fp_pkg;
   localparam int VarW = 62;
   localparam logic [VarW-1:0] VarMax = {VarW{1'b1}};
   localparam logic [VarW-1:0] CapMax = VarW'((64'd1 << 30) - 64'd1);
   localparam logic [VarW-1:0] BlkMax = VarW'((64'd1 << 16) - 64'd1);
   localparam logic [VarW-1:0] IdHeaderList  = VarW'(6);
   localparam logic [VarW-1:0] IdPlaceholder = VarW'(9);
   localparam logic [VarW-1:0] IdCapacity    = VarW'(1);
   localparam logic [VarW-1:0] IdBlocked     = VarW'(7);

   // Frame type codes.
   localparam logic [VarW-1:0] FtData        = VarW'(0);
   localparam logic [VarW-1:0] FtHeaders     = VarW'(1);
   localparam logic [VarW-1:0] FtPriority    = VarW'(2);
   localparam logic [VarW-1:0] FtCancelPush  = VarW'(3);
   localparam logic [VarW-1:0] FtSettings    = VarW'(4);
   localparam logic [VarW-1:0] FtPushPromise = VarW'(5);
   localparam logic [VarW-1:0] FtGoaway      = VarW'(7);
   localparam logic [VarW-1:0] FtMaxPushId   = VarW'(13);
   localparam logic [VarW-1:0] FtDupPush     = VarW'(14);

   typedef enum logic [1:0] {
      KIND_PARSED = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_BAD    = 2'd2
   } kind_type;

   typedef enum logic [10:0] {
      PH_TYPE     = 11'b00000000001,
      PH_LEN      = 11'b00000000010,
      PH_PRI_BYTE = 11'b00000000100,
      PH_PRI_ID1  = 11'b00000001000,
      PH_PRI_ID2  = 11'b00000010000,
      PH_WEIGHT   = 11'b00000100000,
      PH_ONE_ID   = 11'b00001000000,
      PH_PP_ID    = 11'b00010000000,
      PH_SET_ID   = 11'b00100000000,
      PH_SET_VAL  = 11'b01000000000,
      PH_PAYLOAD  = 11'b10000000000
   } phase_type;

   typedef enum logic [2:0] {
      SLOT_NONE = 3'd0,
      SLOT_HDR  = 3'd1,
      SLOT_PH   = 3'd2,
      SLOT_CAP  = 3'd3,
      SLOT_BLK  = 3'd4
   } slot_type;

   typedef struct packed {
      logic [1:0]      out_kind;
      logic [VarW-1:0] frame_type;
      logic [VarW-1:0] buffer_length;
      logic [VarW-1:0] first_id;
      logic [VarW-1:0] second_id;
      logic [1:0]      element_type;
      logic [1:0]      dependency_type;
      logic [7:0]      byte_value;
      logic [VarW-1:0] max_header_list;
      logic [VarW-1:0] placeholders;
      logic [29:0]     table_capacity;
      logic [15:0]     blocked_streams;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/h3fp_if.sv
// Valid/ready channel interfaces for the HTTP/3 frame parser.
// Depends on h3fp_pkg.
`default_nettype none
interface h3fp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface h3fp_rsp_if;
   logic                 valid;
   logic                 ready;
   h3fp_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/http3_frame_parser_top.sv
// HTTP/3 frame parser top level: byte-serial varint and frame body decoder.
// Depends on h3fp_pkg and the channel interfaces in h3fp_if.sv.
//
//  channel   direction  payload
//  req_      in         data_byte (8)
//  rsp_      out        frame / payload byte / malformed report
//
// One byte is taken per cycle; its result, if any, appears in the output
// register in the next cycle. The parse state sits in one set of registers
// updated by single-pass logic, so throughput is one byte per clock.
// A byte is taken whenever the output register is empty or being drained.
// Reset (synchronous) returns the parser to waiting for a frame type.
`default_nettype none
module http3_frame_parser_top (
   input wire logic  clock,
   input wire logic  reset,
   h3fp_req_if.sink  req_ch,
   h3fp_rsp_if.source rsp_ch
);
   import h3fp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [VarW-1:0]   acc_ff, acc_in;
   logic [2:0]        left_ff, left_in;
   logic [VarW-1:0]   type_ff, type_in;
   logic [VarW-1:0]   len_ff, len_in;
   slot_type          slot_ff, slot_in;
   logic [VarW-1:0]   id1_ff, id1_in;
   logic [VarW-1:0]   id2_ff, id2_in;
   logic [7:0]        tbyte_ff, tbyte_in;
   logic [VarW-1:0]   hdr_ff, hdr_in;
   logic [VarW-1:0]   plc_ff, plc_in;
   logic [29:0]       cap_ff, cap_in;
   logic [15:0]       blk_ff, blk_in;
   logic              ovalid_ff, ovalid_in;
   rsp_type           out_ff, out_in;

   logic              take;
   logic [7:0]        b;
   logic              first_b;
   logic [3:0]        vsize;
   logic [VarW-1:0]   vacc;
   logic [2:0]        vleft;
   logic              vdone;
   logic              vbounded;
   logic              vfit;
   logic [VarW-1:0]   vlen;
   logic              emit;
   kind_type          kind;

   assign take         = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !ovalid_ff || rsp_ch.ready;
   assign rsp_ch.valid = ovalid_ff;
   assign rsp_ch.payload = out_ff;
   assign b = req_ch.data_byte;

   // Varint byte step shared by every varint phase.
   always_comb begin
      first_b  = (left_ff == 3'd0);
      vsize    = 4'd1 << b[7:6];
      vbounded = !(phase_ff == PH_TYPE || phase_ff == PH_LEN);
      vfit     = !(first_b && vbounded && (VarW'(vsize) > len_ff));
      vlen     = (first_b && vbounded) ? len_ff - VarW'(vsize) : len_ff;
      if (first_b) begin
         vacc  = VarW'(b[5:0]);
         vleft = 3'(vsize - 4'd1);
      end else begin
         vacc  = {acc_ff[VarW-9:0], b};
         vleft = left_ff - 3'd1;
      end
      vdone = (vleft == 3'd0);
   end

   // Next-state and result logic for one byte.
   always_comb begin
      phase_in = phase_ff; acc_in = acc_ff; left_in = left_ff;
      type_in = type_ff; len_in = len_ff; slot_in = slot_ff;
      id1_in = id1_ff; id2_in = id2_ff; tbyte_in = tbyte_ff;
      hdr_in = hdr_ff; plc_in = plc_ff; cap_in = cap_ff; blk_in = blk_ff;
      emit = 1'b0;
      kind = KIND_PARSED;
      out_in = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            acc_in = vacc; left_in = vleft;
            if (vdone) begin
               type_in = vacc; phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            acc_in = vacc; left_in = vleft;
            if (vdone) begin
               len_in = vacc;
               phase_in = PH_TYPE;
               case (type_ff)
                  FtData, FtHeaders: begin
                     emit = 1'b1;
                     out_in.buffer_length = vacc;
                     if (vacc != '0) phase_in = PH_PAYLOAD;
                  end
                  FtPriority: begin
                     if (vacc == '0) begin
                        emit = 1'b1; kind = KIND_BAD;
                     end else phase_in = PH_PRI_BYTE;
                  end
                  FtCancelPush, FtGoaway, FtMaxPushId, FtDupPush: begin
                     if (vacc == '0) begin
                        emit = 1'b1; kind = KIND_BAD;
                     end else phase_in = PH_ONE_ID;
                  end
                  FtSettings: begin
                     hdr_in = VarMax; plc_in = '0; cap_in = '0; blk_in = '0;
                     if (vacc == '0) begin
                        emit = 1'b1;
                        out_in.max_header_list = VarMax;
                     end else phase_in = PH_SET_ID;
                  end
                  FtPushPromise: begin
                     if (vacc == '0) begin
                        emit = 1'b1; kind = KIND_BAD;
                     end else phase_in = PH_PP_ID;
                  end
                  default: begin
                     emit = 1'b1;
                     if (vacc != '0) kind = KIND_BAD;
                  end
               endcase
            end
         end
         PH_PRI_BYTE: begin
            tbyte_in = b;
            len_in = len_ff - VarW'(1);
            if (len_in == '0) begin
               emit = 1'b1; kind = KIND_BAD;
            end else phase_in = PH_PRI_ID1;
         end
         PH_WEIGHT: begin
            len_in = len_ff - VarW'(1);
            emit = 1'b1;
            phase_in = PH_TYPE;
            if (len_in != '0) kind = KIND_BAD;
            else begin
               out_in.first_id = id1_ff;
               out_in.second_id = id2_ff;
               out_in.element_type = tbyte_ff[7:6];
               out_in.dependency_type = tbyte_ff[5:4];
               out_in.byte_value = b;
            end
         end
         PH_PAYLOAD: begin
            emit = 1'b1; kind = KIND_BYTE;
            out_in.byte_value = b;
            if (len_ff != '0) len_in = len_ff - VarW'(1);
            if (len_in == '0) phase_in = PH_TYPE;
         end
         default: begin
            // Bounded varint body fields.
            if (!vfit) begin
               emit = 1'b1; kind = KIND_BAD;
            end else begin
               acc_in = vacc; left_in = vleft; len_in = vlen;
               if (vdone) begin
                  case (phase_ff)
                     PH_PRI_ID1: begin
                        id1_in = vacc;
                        if (vlen == '0) begin
                           emit = 1'b1; kind = KIND_BAD;
                        end else phase_in = PH_PRI_ID2;
                     end
                     PH_PRI_ID2: begin
                        id2_in = vacc;
                        if (vlen == '0) begin
                           emit = 1'b1; kind = KIND_BAD;
                        end else phase_in = PH_WEIGHT;
                     end
                     PH_ONE_ID: begin
                        id1_in = vacc; emit = 1'b1; phase_in = PH_TYPE;
                        if (vlen != '0) kind = KIND_BAD;
                        else out_in.first_id = vacc;
                     end
                     PH_PP_ID: begin
                        id1_in = vacc; emit = 1'b1;
                        out_in.buffer_length = vlen;
                        out_in.first_id = vacc;
                        phase_in = (vlen != '0) ? PH_PAYLOAD : PH_TYPE;
                     end
                     PH_SET_ID: begin
                        if (vacc == IdHeaderList) slot_in = SLOT_HDR;
                        else if (vacc == IdPlaceholder) slot_in = SLOT_PH;
                        else if (vacc == IdCapacity) slot_in = SLOT_CAP;
                        else if (vacc == IdBlocked) slot_in = SLOT_BLK;
                        else slot_in = SLOT_NONE;
                        if (vlen == '0) begin
                           emit = 1'b1; kind = KIND_BAD;
                        end else phase_in = PH_SET_VAL;
                     end
                     default: begin
                        case (slot_ff)
                           SLOT_HDR: hdr_in = vacc;
                           SLOT_PH:  plc_in = vacc;
                           SLOT_CAP: begin
                              if (vacc > CapMax) begin
                                 emit = 1'b1; kind = KIND_BAD;
                              end else cap_in = vacc[29:0];
                           end
                           SLOT_BLK: begin
                              if (vacc > BlkMax) begin
                                 emit = 1'b1; kind = KIND_BAD;
                              end else blk_in = vacc[15:0];
                           end
                           default: ;
                        endcase
                        if (!emit) begin
                           if (vlen != '0) phase_in = PH_SET_ID;
                           else begin
                              emit = 1'b1;
                              out_in.max_header_list = hdr_in;
                              out_in.placeholders = plc_in;
                              out_in.table_capacity = cap_in;
                              out_in.blocked_streams = blk_in;
                              phase_in = PH_TYPE;
                           end
                        end
                     end
                  endcase
               end
            end
         end
      endcase
      // A malformed frame drops everything and restarts at the type.
      if (emit && kind == KIND_BAD) begin
         out_in = '0;
         phase_in = PH_TYPE; left_in = 3'd0; len_in = '0;
      end
      out_in.out_kind = kind;
      out_in.frame_type = type_ff;
   end

   // Output register occupancy: drained by the sink, filled by a new result.
   always_comb begin
      ovalid_in = ovalid_ff;
      if (rsp_ch.ready) ovalid_in = 1'b0;
      if (take && emit) ovalid_in = 1'b1;
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE; acc_ff <= '0; left_ff <= '0; type_ff <= '0;
         len_ff <= '0; slot_ff <= SLOT_NONE; id1_ff <= '0; id2_ff <= '0;
         tbyte_ff <= '0; hdr_ff <= VarMax; plc_ff <= '0; cap_ff <= '0;
         blk_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; acc_ff <= acc_in; left_ff <= left_in;
            type_ff <= type_in; len_ff <= len_in; slot_ff <= slot_in;
            id1_ff <= id1_in; id2_ff <= id2_in; tbyte_ff <= tbyte_in;
            hdr_ff <= hdr_in; plc_ff <= plc_in; cap_ff <= cap_in;
            blk_ff <= blk_in;
         end
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) out_ff <= out_in;
   end

   // Checks on the parser's own state.
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff)) else $error("phase register not one-hot");
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> len_ff != '0)
      else $error("payload phase with no length left");
   a_bad_restart: assert property (@(posedge clock) disable iff (reset)
      take && emit && kind == KIND_BAD |=> phase_ff == PH_TYPE && left_ff == 3'd0)
      else $error("malformed frame did not restart parser");
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the HTTP/3 frame parser (http3_frame_parser_top).
// Depends on h3fp_pkg and the channel interfaces in h3fp_if.sv.
`timescale 1ns / 1ps
import h3fp_pkg::*;

class frame_scoreboard;
   // Parser state mirrored from the block's behavior.
   phase_type phase;
   logic [63:0] accum;
   int unsigned vleft;
   logic [VarW-1:0] ftype, len_left, id1, id2, hdr_list, phold, cap, blk;
   logic [7:0] tbyte;
   slot_type slot;
   rsp_type pending[$];
   int mismatches;

   function void clear_state();
      phase = PH_TYPE; accum = '0; vleft = 0; ftype = '0; len_left = '0;
      id1 = '0; id2 = '0; tbyte = '0; slot = SLOT_NONE;
      hdr_list = VarMax; phold = '0; cap = '0; blk = '0;
      pending.delete(); mismatches = 0;
   endfunction

   function rsp_type blank(kind_type k);
      rsp_type r;
      r = '0;
      r.out_kind = k;
      r.frame_type = ftype;
      return r;
   endfunction

   function void push_bad();
      pending.push_back(blank(KIND_BAD));
      phase = PH_TYPE; vleft = 0; len_left = '0;
   endfunction

   function void push_settings();
      rsp_type r;
      r = blank(KIND_PARSED);
      r.max_header_list = hdr_list; r.placeholders = phold;
      r.table_capacity = cap[29:0]; r.blocked_streams = blk[15:0];
      pending.push_back(r);
      phase = PH_TYPE;
   endfunction

   // Returns 1 when complete, 0 when more bytes follow, -1 when it overruns the frame.
   function int varint_byte(logic [7:0] b, bit bounded);
      int unsigned sz;
      if (vleft == 0) begin
         sz = 1 << b[7:6];
         if (bounded) begin
            if (VarW'(sz) > len_left) return -1;
            len_left -= VarW'(sz);
         end
         accum = {58'd0, b[5:0]};
         vleft = sz - 1;
      end else begin
         accum = ((accum << 8) | {56'd0, b}) & {2'b00, VarMax};
         vleft--;
      end
      return (vleft == 0) ? 1 : 0;
   endfunction

   function void begin_body();
      rsp_type r;
      case (ftype)
         FtData, FtHeaders: begin
            r = blank(KIND_PARSED);
            r.buffer_length = len_left;
            pending.push_back(r);
            phase = (len_left > 0) ? PH_PAYLOAD : PH_TYPE;
         end
         FtPriority: if (len_left == 0) push_bad(); else phase = PH_PRI_BYTE;
         FtCancelPush, FtGoaway, FtMaxPushId, FtDupPush:
            if (len_left == 0) push_bad(); else phase = PH_ONE_ID;
         FtSettings: begin
            hdr_list = VarMax; phold = '0; cap = '0; blk = '0;
            if (len_left == 0) push_settings(); else phase = PH_SET_ID;
         end
         FtPushPromise: if (len_left == 0) push_bad(); else phase = PH_PP_ID;
         default: begin
            if (len_left > 0) push_bad();
            else begin
               pending.push_back(blank(KIND_PARSED));
               phase = PH_TYPE;
            end
         end
      endcase
   endfunction

   // Notes one accepted input transaction and queues any expected result.
   function void note_byte(logic [7:0] b);
      rsp_type r;
      int st;
      case (phase)
         PH_TYPE: if (varint_byte(b, 0) == 1) begin
            ftype = accum[VarW-1:0]; phase = PH_LEN;
         end
         PH_LEN: if (varint_byte(b, 0) == 1) begin
            len_left = accum[VarW-1:0]; begin_body();
         end
         PH_PRI_BYTE: begin
            tbyte = b; len_left--;
            if (len_left == 0) push_bad(); else phase = PH_PRI_ID1;
         end
         PH_WEIGHT: begin
            len_left--;
            if (len_left > 0) push_bad();
            else begin
               r = blank(KIND_PARSED);
               r.first_id = id1; r.second_id = id2;
               r.element_type = tbyte[7:6]; r.dependency_type = tbyte[5:4];
               r.byte_value = b;
               pending.push_back(r);
               phase = PH_TYPE;
            end
         end
         PH_PAYLOAD: begin
            r = blank(KIND_BYTE);
            r.byte_value = b;
            pending.push_back(r);
            if (len_left > 0) len_left--;
            if (len_left == 0) phase = PH_TYPE;
         end
         default: begin
            st = varint_byte(b, 1);
            if (st < 0) push_bad();
            else if (st == 1) finish_field();
         end
      endcase
   endfunction

   // A bounded body varint has just completed.
   function void finish_field();
      rsp_type r;
      logic [VarW-1:0] v;
      v = accum[VarW-1:0];
      case (phase)
         PH_PRI_ID1: begin
            id1 = v;
            if (len_left == 0) push_bad(); else phase = PH_PRI_ID2;
         end
         PH_PRI_ID2: begin
            id2 = v;
            if (len_left == 0) push_bad(); else phase = PH_WEIGHT;
         end
         PH_ONE_ID: begin
            id1 = v;
            if (len_left > 0) push_bad();
            else begin
               r = blank(KIND_PARSED); r.first_id = v;
               pending.push_back(r); phase = PH_TYPE;
            end
         end
         PH_PP_ID: begin
            id1 = v;
            r = blank(KIND_PARSED);
            r.buffer_length = len_left; r.first_id = v;
            pending.push_back(r);
            phase = (len_left > 0) ? PH_PAYLOAD : PH_TYPE;
         end
         PH_SET_ID: begin
            if (v == IdHeaderList) slot = SLOT_HDR;
            else if (v == IdPlaceholder) slot = SLOT_PH;
            else if (v == IdCapacity) slot = SLOT_CAP;
            else if (v == IdBlocked) slot = SLOT_BLK;
            else slot = SLOT_NONE;
            if (len_left == 0) push_bad(); else phase = PH_SET_VAL;
         end
         default: begin
            if (slot == SLOT_CAP && v > CapMax) begin push_bad(); return; end
            if (slot == SLOT_BLK && v > BlkMax) begin push_bad(); return; end
            case (slot)
               SLOT_HDR: hdr_list = v;
               SLOT_PH:  phold = v;
               SLOT_CAP: cap = v;
               SLOT_BLK: blk = v;
               default: ;
            endcase
            if (len_left > 0) phase = PH_SET_ID;
            else push_settings();
         end
      endcase
   endfunction

   // Compares one accepted result transaction with the oldest expectation.
   function void check_result(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result: %p", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   h3fp_req_if req_ch();
   h3fp_rsp_if rsp_ch();
   frame_scoreboard frames;
   bit stall_long = 0;
   bit stim_done = 0;
   logic [61:0] set_ids[8], set_vals[8];

   http3_frame_parser_top u_dut (.clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 0; req_ch.data_byte = 0; rsp_ch.ready = 0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Offers one byte and waits for the handshake.
   task automatic send_byte(logic [7:0] b, bit idle_ok);
      int g;
      g = idle_ok ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1; req_ch.data_byte <= b;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      frames.note_byte(b);
      @(negedge clock);
   endtask

   // Emits a varint of the given value using a chosen size code.
   task automatic send_varint(logic [61:0] v, int code, bit idle_ok);
      int n;
      logic [63:0] w;
      n = 1 << code;
      w = {code[1:0], v} ;
      w = w & ((n == 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8*n)) - 64'd1));
      w[8*n-1 -: 2] = code[1:0];
      for (int i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8], idle_ok);
   endtask

   function automatic int min_code(logic [61:0] v);
      if (v < 62'd64) return 0;
      if (v < 62'd16384) return 1;
      if (v < 62'd1073741824) return 2;
      return 3;
   endfunction

   function automatic logic [61:0] rand_val();
      case ($urandom_range(0, 4))
         0: return 62'($urandom_range(0, 63));
         1: return 62'($urandom_range(0, 16383));
         2: return 62'({$urandom, $urandom}) & 62'h3FFF_FFFF;
         3: return 62'({$urandom, $urandom});
         default: return $urandom_range(0, 1) ? VarMax : '0;
      endcase
   endfunction

   function automatic int vsize(logic [61:0] v);
      return 1 << min_code(v);
   endfunction

   // Settings pairs replayed from a saved list so the declared length matches.
   task automatic frames_settings_body(int n, bit idle_ok);
      for (int i = 0; i < n; i++) begin
         send_varint(set_ids[i], min_code(set_ids[i]), idle_ok);
         send_varint(set_vals[i], min_code(set_vals[i]), idle_ok);
      end
   endtask

   // Settings frame whose length matches its body, now and then one byte too long.
   task automatic send_settings(bit idle_ok);
      int n;
      logic [61:0] len;
      n = $urandom_range(0, 5);
      len = '0;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: set_ids[i] = IdHeaderList; 1: set_ids[i] = IdPlaceholder;
            2: set_ids[i] = IdCapacity;   3: set_ids[i] = IdBlocked;
            default: set_ids[i] = rand_val();
         endcase
         if (set_ids[i] == IdCapacity)
            set_vals[i] = ($urandom_range(0, 7) == 0) ? rand_val() : rand_val() & CapMax;
         else if (set_ids[i] == IdBlocked)
            set_vals[i] = ($urandom_range(0, 7) == 0) ? rand_val() :
                          62'($urandom_range(0, 65535));
         else set_vals[i] = rand_val();
         len += 62'(vsize(set_ids[i]) + vsize(set_vals[i]));
      end
      if ($urandom_range(0, 7) == 0) len += 62'd1;
      send_varint(FtSettings, 0, idle_ok); send_varint(len, min_code(len), idle_ok);
      frames_settings_body(n, idle_ok);
   endtask

   // One well-formed frame with random content; sometimes slightly corrupted.
   task automatic send_frame(bit idle_ok);
      int kind, plen;
      logic [61:0] a, b, len;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            plen = $urandom_range(0, 6);
            send_varint(62'(kind), $urandom_range(0, 1), idle_ok);
            send_varint(62'(plen), min_code(62'(plen)), idle_ok);
            repeat (plen) send_byte(8'($urandom), idle_ok);
         end
         2: begin
            a = rand_val(); b = rand_val();
            len = 62'(2 + vsize(a) + vsize(b));
            if ($urandom_range(0, 5) == 0) len = 62'(len + $urandom_range(0, 2) - 1);
            send_varint(FtPriority, 0, idle_ok);
            send_varint(len, min_code(len), idle_ok);
            send_byte(8'($urandom), idle_ok);
            send_varint(a, min_code(a), idle_ok); send_varint(b, min_code(b), idle_ok);
            send_byte(8'($urandom), idle_ok);
         end
         3: begin
            a = rand_val();
            len = 62'(vsize(a));
            send_varint($urandom_range(0, 1) ? FtGoaway : FtCancelPush, 0, idle_ok);
            send_varint(len, 0, idle_ok);
            send_varint(a, min_code(a), idle_ok);
         end
         4: begin
            a = rand_val();
            plen = $urandom_range(0, 4);
            len = 62'(vsize(a) + plen);
            send_varint(FtPushPromise, 0, idle_ok); send_varint(len, 0, idle_ok);
            send_varint(a, min_code(a), idle_ok);
            repeat (plen) send_byte(8'($urandom), idle_ok);
         end
         5, 6, 7: send_settings(idle_ok);
         8: begin
            a = 62'(8 + $urandom_range(0, 100));
            send_varint(a, min_code(a), idle_ok);
            send_varint(($urandom_range(0, 3) == 0) ? 62'd1 : 62'd0, 0, idle_ok);
         end
         default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), idle_ok);
      endcase
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      @(negedge clock);
      while (frames.pending.size() != 0) @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (stall_long) rsp_ch.ready <= 0;
      else rsp_ch.ready <= ($urandom_range(0, 9) < 7) || stim_done;
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) frames.check_result(rsp_ch.payload);

   initial begin
      int sent_frames;
      frames = new();
      frames.clear_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes and the special cases.
      send_varint(FtData, 0, 0); send_varint(62'd0, 0, 0);           // empty DATA
      send_varint(FtHeaders, 3, 0); send_varint(62'd2, 0, 0);        // HEADERS, 8-byte type
      send_byte(8'hFF, 0); send_byte(8'h00, 0);
      send_varint(FtSettings, 0, 0); send_varint(62'd0, 0, 0);       // SETTINGS defaults
      send_varint(FtGoaway, 0, 0); send_varint(62'd8, 0, 0);         // GOAWAY max id
      send_varint(VarMax, 3, 0);
      send_varint(FtCancelPush, 0, 0); send_varint(62'd2, 0, 0);     // overrun
      send_varint(62'd0, 3, 0);
      send_varint(62'h21, 0, 0); send_varint(62'd0, 0, 0);           // unknown, empty
      send_varint(62'h21, 0, 0); send_varint(62'd1, 0, 0);           // unknown, nonzero
      send_varint(FtPriority, 0, 0); send_varint(62'd1, 0, 0);       // priority too short
      send_byte(8'hF0, 0);
      send_varint(FtMaxPushId, 0, 0); send_varint(62'd2, 0, 0);      // leftover
      send_varint(62'd5, 0, 0);

      // Long receiver hold-off while bytes keep arriving.
      fork
         begin stall_long <= 1; repeat (200) @(negedge clock); stall_long <= 0; end
         repeat (60) send_frame(0);
      join
      wait_drained();

      sent_frames = 0;
      while (sent_frames < 130) begin
         if ($urandom_range(0, 3) == 0) send_settings(1);
         else send_frame($urandom_range(0, 3) != 0);
         sent_frames++;
         if (sent_frames == 65) wait_drained();
      end
      stim_done <= 1;
      wait_drained();
      repeat (10) @(negedge clock);
      if (frames.mismatches == 0 && frames.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
